// ===== rtl/core/sbf_pkg.sv =====
// ---------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants for the spring / bungee force pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package sbf_pkg;

	localparam int unsigned MAG_W  = 33;  // |p - q| per axis
	localparam int unsigned SUM_W  = 66;  // sum of three squares
	localparam int unsigned LEN_W  = 34;  // floor(sqrt(sum))
	localparam int unsigned QUO_W  = 33;  // divider quotient bits
	localparam int unsigned CFG_W  = 31;
	localparam int unsigned IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [IDX_W-1:0] REG_K    = 2'd1;
	localparam logic [IDX_W-1:0] REG_REST = 2'd2;

	localparam logic MODE_SPRING = 1'b0;
	localparam logic MODE_BUNGEE = 1'b1;

	// per-axis data that rides along the square root
	typedef struct packed {
		logic [2:0]            neg;  // d > 0, force points negative
		logic [2:0]            nz;   // d != 0
		logic [2:0][MAG_W-1:0] mag;
	} sbf_side_t;

	// flags that ride along the divider
	typedef struct packed {
		logic [2:0] ovf;      // quotient at least 2^33
		logic [2:0] neg;
		logic [2:0] nz;
		logic       kill;     // zero length or slack bungee
		logic       applied;
	} sbf_dside_t;

endpackage
`default_nettype wire

// ===== rtl/core/sbf_isqrt.sv =====
// ---------------------------------------------------------------------------
// sbf_isqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module sbf_isqrt (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic [sbf_pkg::SUM_W-1:0]       in_sum,
	input  wire sbf_pkg::sbf_side_t              in_side,
	output logic                                 out_valid,
	output logic [sbf_pkg::LEN_W-1:0]            out_root,
	output sbf_pkg::sbf_side_t                   out_side
);
	import sbf_pkg::*;

	localparam int unsigned RB = LEN_W;
	localparam int unsigned TW = SUM_W + 4;

	logic             vld_sn  [0:RB];
	logic [SUM_W-1:0] rem_sn  [0:RB];
	logic [LEN_W-1:0] root_sn [0:RB];
	sbf_side_t        side_sn [0:RB];

	assign vld_sn[0]  = in_valid;
	assign rem_sn[0]  = in_sum;
	assign root_sn[0] = '0;
	assign side_sn[0] = in_side;

	for (genvar j = 0; j < RB; j++) begin : g_stage
		localparam int unsigned B = RB - 1 - j;
		logic [TW-1:0] trial;
		logic          take;

		// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
		always_comb begin
			trial = (TW'(root_sn[j]) << (B + 1)) | (TW'(1) << (2 * B));
			take  = TW'(rem_sn[j]) >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[j+1] <= 1'b0;
			end else begin
				vld_sn[j+1] <= vld_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[j+1]  <= take ? SUM_W'(TW'(rem_sn[j]) - trial) : rem_sn[j];
			root_sn[j+1] <= take ? (root_sn[j] | (LEN_W'(1) << B)) : root_sn[j];
			side_sn[j+1] <= side_sn[j];
		end
	end

	assign out_valid = vld_sn[RB];
	assign out_root  = root_sn[RB];
	assign out_side  = side_sn[RB];

endmodule
`default_nettype wire

// ===== rtl/core/sbf_div.sv =====
// ---------------------------------------------------------------------------
// sbf_div
// Three-lane pipelined restoring divider sharing one divisor.
// ---------------------------------------------------------------------------
`default_nettype none
module sbf_div (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic [2:0][sbf_pkg::LEN_W-1:0]       in_rem,   // top part, below divisor
	input  wire logic [2:0][sbf_pkg::QUO_W-1:0]       in_low,   // bits still to shift in
	input  wire logic [sbf_pkg::LEN_W-1:0]            in_den,
	input  wire sbf_pkg::sbf_dside_t                  in_side,
	output logic                                      out_valid,
	output logic [2:0][sbf_pkg::QUO_W-1:0]            out_quo,
	output sbf_pkg::sbf_dside_t                       out_side
);
	import sbf_pkg::*;

	localparam int unsigned NS = QUO_W;

	logic                        vld_sn  [0:NS];
	logic [2:0][LEN_W-1:0]       rem_sn  [0:NS];
	logic [2:0][QUO_W-1:0]       dvd_sn  [0:NS];
	logic [LEN_W-1:0]            den_sn  [0:NS];
	sbf_dside_t                  side_sn [0:NS];

	assign vld_sn[0]  = in_valid;
	assign rem_sn[0]  = in_rem;
	assign dvd_sn[0]  = in_low;
	assign den_sn[0]  = in_den;
	assign side_sn[0] = in_side;

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic [2:0][LEN_W:0]   r2;
		logic [2:0]            ge;
		logic [2:0][LEN_W-1:0] rem_nx;
		logic [2:0][QUO_W-1:0] dvd_nx;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				r2[l]     = {rem_sn[j][l], dvd_sn[j][l][QUO_W-1]};
				ge[l]     = r2[l] >= {1'b0, den_sn[j]};
				rem_nx[l] = ge[l] ? LEN_W'(r2[l] - {1'b0, den_sn[j]}) : LEN_W'(r2[l]);
				dvd_nx[l] = {dvd_sn[j][l][QUO_W-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[j+1] <= 1'b0;
			end else begin
				vld_sn[j+1] <= vld_sn[j];
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[j+1]  <= rem_nx;
			dvd_sn[j+1]  <= dvd_nx;
			den_sn[j+1]  <= den_sn[j];
			side_sn[j+1] <= side_sn[j];
		end
	end

	assign out_valid = vld_sn[NS];
	assign out_quo   = dvd_sn[NS];
	assign out_side  = side_sn[NS];

endmodule
`default_nettype wire

// ===== rtl/core/spring_bungee_force.sv =====
// ---------------------------------------------------------------------------
// spring_bungee_force
// Hooke spring / bungee force on a particle, signed fixed point, pipelined.
// ---------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start, busy          self_x/y/z, end_x/y/z
//  result    done (one cycle)     force_x/y/z, applied, clipped
//  config    wr_en                wr_index, wr_data
//
// One item per cycle; busy is never raised. The square root takes one bit
// per stage (34 stages) and the divider one quotient bit per stage (33
// stages), plus eight stages of subtract, square, sum, magnitude,
// multiplies and saturation. Reset empties the pipeline and loads the
// register defaults. There is no backpressure on results.
// ---------------------------------------------------------------------------
`default_nettype none
module spring_bungee_force #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [31:0]            self_x,
	input  wire logic signed [31:0]            self_y,
	input  wire logic signed [31:0]            self_z,
	input  wire logic signed [31:0]            end_x,
	input  wire logic signed [31:0]            end_y,
	input  wire logic signed [31:0]            end_z,
	output logic                               done,
	output logic signed [31:0]                 force_x,
	output logic signed [31:0]                 force_y,
	output logic signed [31:0]                 force_z,
	output logic                               applied,
	output logic                               clipped,
	input  wire logic                          wr_en,
	input  wire logic [sbf_pkg::IDX_W-1:0]     wr_index,
	input  wire logic [sbf_pkg::CFG_W-1:0]     wr_data
);
	import sbf_pkg::*;

	localparam int unsigned PW  = 64;                // k * m, wraps at 64 bits
	localparam int unsigned KW  = PW - FRAC_BITS;    // kmag
	localparam int unsigned HW  = KW - 32;           // kmag upper slice
	localparam int unsigned NW  = KW + MAG_W;        // kmag * |d|
	localparam int unsigned LAT = 75;

	// configuration
	logic             mode_q;
	logic [CFG_W-1:0] k_q, rest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SPRING;
			k_q    <= CFG_W'(65536);
			rest_q <= CFG_W'(65536);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE: mode_q <= wr_data[0];
				REG_K:    k_q    <= wr_data;
				REG_REST: rest_q <= wr_data;
				default:  ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: separation
	logic                    vld_s1;
	sbf_side_t               side_s1;
	logic [2:0][32:0]        dv;
	logic [2:0][31:0]        pin, qin;

	always_comb begin
		pin = {self_z, self_y, self_x};
		qin = {end_z, end_y, end_x};
		for (int l = 0; l < 3; l++) begin
			dv[l] = {pin[l][31], pin[l]} - {qin[l][31], qin[l]};
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			side_s1.neg[l] <= !dv[l][32] && (dv[l] != '0);
			side_s1.nz[l]  <= dv[l] != '0;
			side_s1.mag[l] <= dv[l][32] ? MAG_W'(-dv[l]) : dv[l];
		end
	end

	// stage 2: squares
	logic                    vld_s2;
	sbf_side_t               side_s2;
	logic [2:0][SUM_W-1:0]   sq_s2;

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		for (int l = 0; l < 3; l++) begin
			sq_s2[l] <= SUM_W'(side_s1.mag[l]) * SUM_W'(side_s1.mag[l]);
		end
	end

	// stage 3: sum
	logic                    vld_s3;
	sbf_side_t               side_s3;
	logic [SUM_W-1:0]        sum_s3;

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	logic             rt_valid;
	logic [LEN_W-1:0] rt_len;
	sbf_side_t        rt_side;

	sbf_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s3),
		.in_sum    (sum_s3),
		.in_side   (side_s3),
		.out_valid (rt_valid),
		.out_root  (rt_len),
		.out_side  (rt_side)
	);

	// stage 4: |len - rest| and the special cases
	logic             vld_s4, kill_s4, appl_s4;
	logic [LEN_W-1:0] m_s4, len_s4;
	sbf_side_t        side_s4;
	logic             slack;

	assign slack = (mode_q == MODE_BUNGEE) && (rt_len <= LEN_W'(rest_q));

	always_ff @(posedge clk) begin
		kill_s4 <= slack || (rt_len == '0);
		appl_s4 <= !slack;
		m_s4    <= (rt_len >= LEN_W'(rest_q)) ? rt_len - LEN_W'(rest_q)
		                                      : LEN_W'(rest_q) - rt_len;
		len_s4  <= rt_len;
		side_s4 <= rt_side;
	end

	// stage 5: kmag = k * m >> FRAC_BITS
	logic             vld_s5, kill_s5, appl_s5;
	logic [KW-1:0]    kmag_s5;
	logic [LEN_W-1:0] len_s5;
	sbf_side_t        side_s5;
	logic [PW-1:0]    kprod;

	assign kprod = PW'(k_q) * PW'(m_s4);

	always_ff @(posedge clk) begin
		kmag_s5 <= kprod[PW-1:FRAC_BITS];
		kill_s5 <= kill_s4;
		appl_s5 <= appl_s4;
		len_s5  <= len_s4;
		side_s5 <= side_s4;
	end

	// stage 6: kmag * |d|, split in two partial products
	logic                    vld_s6, kill_s6, appl_s6;
	logic [2:0][MAG_W+31:0]  plo_s6;
	logic [2:0][HW+MAG_W-1:0] phi_s6;
	logic [LEN_W-1:0]        len_s6;
	sbf_side_t               side_s6;

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			plo_s6[l] <= (MAG_W+32)'(kmag_s5[31:0]) * (MAG_W+32)'(side_s5.mag[l]);
			phi_s6[l] <= (HW+MAG_W)'(kmag_s5[KW-1:32]) * (HW+MAG_W)'(side_s5.mag[l]);
		end
		kill_s6 <= kill_s5;
		appl_s6 <= appl_s5;
		len_s6  <= len_s5;
		side_s6 <= side_s5;
	end

	// stage 7: numerator
	logic                 vld_s7, kill_s7, appl_s7;
	logic [2:0][NW-1:0]   num_s7;
	logic [LEN_W-1:0]     len_s7;
	logic [2:0]           neg_s7, nz_s7;

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			num_s7[l] <= (NW'(phi_s6[l]) << 32) + NW'(plo_s6[l]);
		end
		kill_s7 <= kill_s6;
		appl_s7 <= appl_s6;
		len_s7  <= len_s6;
		neg_s7  <= side_s6.neg;
		nz_s7   <= side_s6.nz;
	end

	// quotient at or above 2^33 is flagged and saturates anyway
	sbf_dside_t             dv_side;
	logic [2:0][LEN_W-1:0]  dv_rem;
	logic [2:0][QUO_W-1:0]  dv_low;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			dv_side.ovf[l] = num_s7[l][NW-1:QUO_W] >= KW'(len_s7);
			dv_rem[l]      = LEN_W'(num_s7[l][NW-1:QUO_W]);
			dv_low[l]      = num_s7[l][QUO_W-1:0];
		end
		dv_side.neg     = neg_s7;
		dv_side.nz      = nz_s7;
		dv_side.kill    = kill_s7;
		dv_side.applied = appl_s7;
	end

	logic                   dq_valid;
	logic [2:0][QUO_W-1:0]  dq_quo;
	sbf_dside_t             dq_side;

	sbf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s7),
		.in_rem    (dv_rem),
		.in_low    (dv_low),
		.in_den    (len_s7),
		.in_side   (dv_side),
		.out_valid (dq_valid),
		.out_quo   (dq_quo),
		.out_side  (dq_side)
	);

	// stage 8: sign and saturation
	logic [2:0][31:0] fv;
	logic [2:0]       fc;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			fv[l] = '0;
			fc[l] = 1'b0;
			if (!dq_side.kill && dq_side.nz[l]) begin
				if (dq_side.neg[l]) begin
					fc[l] = dq_side.ovf[l] || (dq_quo[l] > QUO_W'(33'h080000000));
					fv[l] = fc[l] ? 32'h80000000 : 32'(-dq_quo[l]);
				end else begin
					fc[l] = dq_side.ovf[l] || (dq_quo[l] > QUO_W'(33'h07FFFFFFF));
					fv[l] = fc[l] ? 32'h7FFFFFFF : dq_quo[l][31:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		force_x <= fv[0];
		force_y <= fv[1];
		force_z <= fv[2];
		applied <= dq_side.applied;
		clipped <= |fc;
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= rt_valid;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			done   <= dq_valid;
		end
	end

	a_slack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !applied |-> force_x == '0 && force_y == '0 && force_z == '0 && !clipped)
		else $error("slack bungee item carries a force");

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && clipped |-> force_x == 32'h80000000 || force_x == 32'h7FFFFFFF ||
		                    force_y == 32'h80000000 || force_y == 32'h7FFFFFFF ||
		                    force_z == 32'h80000000 || force_z == 32'h7FFFFFFF)
		else $error("clipped item without a saturated component");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("item lost in the pipeline");

endmodule
`default_nettype wire
